>>> rtl/core/jts_pkg.sv
// Shared types, token codes and character helpers for the JSON token scanner.
package jts_pkg;

    typedef enum logic [4:0] {
        M_IDLE  = 5'd0,
        M_STR   = 5'd1,
        M_ESC   = 5'd2,
        M_HEX   = 5'd3,
        M_KEY   = 5'd4,
        M_MINUS = 5'd5,
        M_ZERO  = 5'd6,
        M_INT   = 5'd7,
        M_DOT   = 5'd8,
        M_FRAC  = 5'd9,
        M_E     = 5'd10,
        M_ESIGN = 5'd11,
        M_EXP   = 5'd12,
        M_HALT  = 5'd13
    } scan_mode_t;

    typedef enum logic [3:0] {
        K_EOF    = 4'd0,
        K_LBRACE = 4'd1,
        K_RBRACE = 4'd2,
        K_LBRACK = 4'd3,
        K_RBRACK = 4'd4,
        K_COMMA  = 4'd5,
        K_COLON  = 4'd6,
        K_STRING = 4'd7,
        K_NUMBER = 4'd8,
        K_TRUE   = 4'd9,
        K_FALSE  = 4'd10,
        K_NULL   = 4'd11,
        K_ERROR  = 4'd12
    } token_kind_t;

    localparam logic [1:0] KW_TRUE  = 2'd0;
    localparam logic [1:0] KW_FALSE = 2'd1;
    localparam logic [1:0] KW_NULL  = 2'd2;

    typedef struct packed {
        token_kind_t kind;
        logic [7:0]  content;
        logic        content_valid;
        logic        done;
    } result_t;

    function automatic result_t mk_result(token_kind_t kind, logic [7:0] content,
                                          logic content_valid, logic done);
        result_t r;
        r.kind          = kind;
        r.content       = content;
        r.content_valid = content_valid;
        r.done          = done;
        return r;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_hex(logic [7:0] c);
        return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
    endfunction

    function automatic logic [2:0] kw_len(logic [1:0] k);
        logic [2:0] len;
        unique case (k)
            KW_TRUE:  len = 3'd4;
            KW_FALSE: len = 3'd5;
            KW_NULL:  len = 3'd4;
            default:  len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] kw_char(logic [1:0] k, logic [2:0] p);
        logic [7:0] ch;
        unique case ({k, p})
            {KW_TRUE, 3'd0}:  ch = "t";
            {KW_TRUE, 3'd1}:  ch = "r";
            {KW_TRUE, 3'd2}:  ch = "u";
            {KW_TRUE, 3'd3}:  ch = "e";
            {KW_FALSE, 3'd0}: ch = "f";
            {KW_FALSE, 3'd1}: ch = "a";
            {KW_FALSE, 3'd2}: ch = "l";
            {KW_FALSE, 3'd3}: ch = "s";
            {KW_FALSE, 3'd4}: ch = "e";
            {KW_NULL, 3'd0}:  ch = "n";
            {KW_NULL, 3'd1}:  ch = "u";
            {KW_NULL, 3'd2}:  ch = "l";
            {KW_NULL, 3'd3}:  ch = "l";
            default:          ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic token_kind_t kw_kind(logic [1:0] k);
        token_kind_t kind;
        unique case (k)
            KW_TRUE:  kind = K_TRUE;
            KW_FALSE: kind = K_FALSE;
            KW_NULL:  kind = K_NULL;
            default:  kind = K_ERROR;
        endcase
        return kind;
    endfunction

endpackage

>>> rtl/core/json_token_scanner_unit.sv
// JSON token scanner: one text byte a beat in, token result beats out.
//
// Text bytes enter on the s_ channel, one per beat; s_tlast (or a zero byte) marks the end of
// the text. An accepted byte is held in the input register while it is scanned, and its first
// result is then written to the m_ output register, which drives m_tvalid. The scanner takes
// one byte per cycle while each byte gives at most one result and m_tready is high. A byte
// that gives two results holds the input while its second result waits in a skid register
// until the output register is free. This happens when a number is closed by a byte that
// gives a result of its own (punctuation, another number character, an error, or the end of
// the text with its EOF), and when an error at the end of the text is followed by EOF. After
// an error all bytes are dropped until the end of the text, which gives an EOF result.
module json_token_scanner_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] text_byte
    input  logic       s_tlast,   // end_of_input
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] content_byte
    output logic [4:0] m_tuser,   // [3:0] token_kind, [4] content_valid
    output logic       m_tlast    // token_done
);

    // Input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Scanner state
    jts_pkg::scan_mode_t mode_reg, mode_next;
    logic [1:0] kw_choice_reg, kw_choice_next;
    logic [2:0] kw_pos_reg, kw_pos_next;
    logic [2:0] hex_seen_reg, hex_seen_next;

    // Output register and skid stage
    logic             out_valid_reg, out_valid_next;
    jts_pkg::result_t out_reg, out_next;
    logic             second_valid_reg, second_valid_next;
    jts_pkg::result_t second_reg, second_next;

    logic       out_free;
    logic       process;
    logic [7:0] c;
    logic       end_w;
    logic       ex;

    // Between-token scan, also used for the byte that closes a number
    logic                idle_has;
    jts_pkg::result_t    idle_res;
    jts_pkg::scan_mode_t idle_mode;
    logic                idle_kw;
    logic [1:0]          idle_kc;

    // Step results
    logic [1:0]          res_cnt;
    jts_pkg::result_t    res0, res1;
    logic                do_fail, do_num, do_close;
    jts_pkg::scan_mode_t num_mode;
    logic [2:0]          kw_pos_inc;
    logic [2:0]          hex_inc;
    logic [7:0]          esc_byte;

    assign c     = in_byte_reg;
    assign end_w = in_last_reg || (c == 8'h00);
    assign ex    = (c == "e") || (c == "E");

    assign out_free = !out_valid_reg || m_tready;
    assign process  = in_valid_reg && !second_valid_reg && out_free;
    assign s_tready = !in_valid_reg || process;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.content;
    assign m_tuser  = {out_reg.content_valid, out_reg.kind};
    assign m_tlast  = out_reg.done;

    assign kw_pos_inc = kw_pos_reg + 3'd1;
    assign hex_inc    = hex_seen_reg + 3'd1;

    always_comb begin
        idle_has  = 1'b0;
        idle_res  = jts_pkg::mk_result(jts_pkg::K_EOF, 8'h00, 1'b0, 1'b1);
        idle_mode = jts_pkg::M_IDLE;
        idle_kw   = 1'b0;
        idle_kc   = jts_pkg::KW_TRUE;
        if (end_w) begin
            idle_has = 1'b1;
        end else if (jts_pkg::is_space(c)) begin
            idle_has = 1'b0;
        end else begin
            case (c)
                "{": begin
                    idle_has = 1'b1;
                    idle_res = jts_pkg::mk_result(jts_pkg::K_LBRACE, 8'h00, 1'b0, 1'b1);
                end
                "}": begin
                    idle_has = 1'b1;
                    idle_res = jts_pkg::mk_result(jts_pkg::K_RBRACE, 8'h00, 1'b0, 1'b1);
                end
                "[": begin
                    idle_has = 1'b1;
                    idle_res = jts_pkg::mk_result(jts_pkg::K_LBRACK, 8'h00, 1'b0, 1'b1);
                end
                "]": begin
                    idle_has = 1'b1;
                    idle_res = jts_pkg::mk_result(jts_pkg::K_RBRACK, 8'h00, 1'b0, 1'b1);
                end
                ",": begin
                    idle_has = 1'b1;
                    idle_res = jts_pkg::mk_result(jts_pkg::K_COMMA, 8'h00, 1'b0, 1'b1);
                end
                ":": begin
                    idle_has = 1'b1;
                    idle_res = jts_pkg::mk_result(jts_pkg::K_COLON, 8'h00, 1'b0, 1'b1);
                end
                "\"": begin
                    idle_mode = jts_pkg::M_STR;
                end
                "-": begin
                    idle_has  = 1'b1;
                    idle_res  = jts_pkg::mk_result(jts_pkg::K_NUMBER, c, 1'b1, 1'b0);
                    idle_mode = jts_pkg::M_MINUS;
                end
                "0": begin
                    idle_has  = 1'b1;
                    idle_res  = jts_pkg::mk_result(jts_pkg::K_NUMBER, c, 1'b1, 1'b0);
                    idle_mode = jts_pkg::M_ZERO;
                end
                "t": begin
                    idle_kw   = 1'b1;
                    idle_kc   = jts_pkg::KW_TRUE;
                    idle_mode = jts_pkg::M_KEY;
                end
                "f": begin
                    idle_kw   = 1'b1;
                    idle_kc   = jts_pkg::KW_FALSE;
                    idle_mode = jts_pkg::M_KEY;
                end
                "n": begin
                    idle_kw   = 1'b1;
                    idle_kc   = jts_pkg::KW_NULL;
                    idle_mode = jts_pkg::M_KEY;
                end
                default: begin
                    idle_has = 1'b1;
                    if (jts_pkg::is_digit(c)) begin
                        idle_res  = jts_pkg::mk_result(jts_pkg::K_NUMBER, c, 1'b1, 1'b0);
                        idle_mode = jts_pkg::M_INT;
                    end else begin
                        idle_res  = jts_pkg::mk_result(jts_pkg::K_ERROR, 8'h00, 1'b0, 1'b1);
                        idle_mode = jts_pkg::M_HALT;
                    end
                end
            endcase
        end
    end

    always_comb begin
        res_cnt        = 2'd0;
        res0           = jts_pkg::mk_result(jts_pkg::K_EOF, 8'h00, 1'b0, 1'b1);
        res1           = jts_pkg::mk_result(jts_pkg::K_EOF, 8'h00, 1'b0, 1'b1);
        mode_next      = mode_reg;
        kw_choice_next = kw_choice_reg;
        kw_pos_next    = kw_pos_reg;
        hex_seen_next  = hex_seen_reg;
        do_fail        = 1'b0;
        do_num         = 1'b0;
        do_close       = 1'b0;
        num_mode       = jts_pkg::M_INT;
        esc_byte       = c;

        unique case (mode_reg) inside
            jts_pkg::M_IDLE: begin
                do_close = 1'b0;
                res_cnt   = {1'b0, idle_has};
                res0      = idle_res;
                mode_next = idle_mode;
                if (idle_kw) begin
                    kw_choice_next = idle_kc;
                    kw_pos_next    = 3'd1;
                end
            end
            jts_pkg::M_STR: begin
                if (end_w) begin
                    do_fail = 1'b1;
                end else if (c == "\"") begin
                    mode_next = jts_pkg::M_IDLE;
                    res_cnt   = 2'd1;
                    res0      = jts_pkg::mk_result(jts_pkg::K_STRING, 8'h00, 1'b0, 1'b1);
                end else if (c == "\\") begin
                    mode_next = jts_pkg::M_ESC;
                end else begin
                    res_cnt = 2'd1;
                    res0    = jts_pkg::mk_result(jts_pkg::K_STRING, c, 1'b1, 1'b0);
                end
            end
            jts_pkg::M_ESC: begin
                if (end_w) begin
                    do_fail = 1'b1;
                end else if (c == "u") begin
                    hex_seen_next = 3'd0;
                    mode_next     = jts_pkg::M_HEX;
                end else begin
                    case (c) inside
                        "\"", "\\", "/": esc_byte = c;
                        "b":             esc_byte = 8'h08;
                        "f":             esc_byte = 8'h0c;
                        "n":             esc_byte = 8'h0a;
                        "r":             esc_byte = 8'h0d;
                        "t":             esc_byte = 8'h09;
                        default: begin
                            esc_byte = c;
                            do_fail  = 1'b1;
                        end
                    endcase
                    if (!do_fail) begin
                        mode_next = jts_pkg::M_STR;
                        res_cnt   = 2'd1;
                        res0      = jts_pkg::mk_result(jts_pkg::K_STRING, esc_byte, 1'b1, 1'b0);
                    end
                end
            end
            jts_pkg::M_HEX: begin
                if (end_w || !jts_pkg::is_hex(c)) begin
                    do_fail = 1'b1;
                end else if (hex_inc >= 3'd4) begin
                    hex_seen_next = 3'd0;
                    mode_next     = jts_pkg::M_STR;
                end else begin
                    hex_seen_next = hex_inc;
                end
            end
            jts_pkg::M_KEY: begin
                if (end_w || (kw_pos_reg >= jts_pkg::kw_len(kw_choice_reg))
                        || (c != jts_pkg::kw_char(kw_choice_reg, kw_pos_reg))) begin
                    do_fail = 1'b1;
                end else if (kw_pos_inc >= jts_pkg::kw_len(kw_choice_reg)) begin
                    kw_pos_next = 3'd0;
                    mode_next   = jts_pkg::M_IDLE;
                    res_cnt     = 2'd1;
                    res0        = jts_pkg::mk_result(jts_pkg::kw_kind(kw_choice_reg), 8'h00,
                                                     1'b0, 1'b1);
                end else begin
                    kw_pos_next = kw_pos_inc;
                end
            end
            jts_pkg::M_MINUS: begin
                if (end_w) begin
                    do_fail = 1'b1;
                end else if (c == "0") begin
                    do_num   = 1'b1;
                    num_mode = jts_pkg::M_ZERO;
                end else if (jts_pkg::is_digit(c)) begin
                    do_num   = 1'b1;
                    num_mode = jts_pkg::M_INT;
                end else begin
                    do_fail = 1'b1;
                end
            end
            jts_pkg::M_ZERO, jts_pkg::M_INT: begin
                if (!end_w && (mode_reg == jts_pkg::M_INT) && jts_pkg::is_digit(c)) begin
                    do_num   = 1'b1;
                    num_mode = jts_pkg::M_INT;
                end else if (!end_w && (c == ".")) begin
                    do_num   = 1'b1;
                    num_mode = jts_pkg::M_DOT;
                end else if (!end_w && ex) begin
                    do_num   = 1'b1;
                    num_mode = jts_pkg::M_E;
                end else begin
                    do_close = 1'b1;
                end
            end
            jts_pkg::M_DOT: begin
                if (!end_w && jts_pkg::is_digit(c)) begin
                    do_num   = 1'b1;
                    num_mode = jts_pkg::M_FRAC;
                end else begin
                    do_fail = 1'b1;
                end
            end
            jts_pkg::M_FRAC: begin
                if (!end_w && jts_pkg::is_digit(c)) begin
                    do_num   = 1'b1;
                    num_mode = jts_pkg::M_FRAC;
                end else if (!end_w && ex) begin
                    do_num   = 1'b1;
                    num_mode = jts_pkg::M_E;
                end else begin
                    do_close = 1'b1;
                end
            end
            jts_pkg::M_E: begin
                if (end_w) begin
                    do_fail = 1'b1;
                end else if ((c == "+") || (c == "-")) begin
                    do_num   = 1'b1;
                    num_mode = jts_pkg::M_ESIGN;
                end else if (jts_pkg::is_digit(c)) begin
                    do_num   = 1'b1;
                    num_mode = jts_pkg::M_EXP;
                end else begin
                    do_fail = 1'b1;
                end
            end
            jts_pkg::M_ESIGN: begin
                if (!end_w && jts_pkg::is_digit(c)) begin
                    do_num   = 1'b1;
                    num_mode = jts_pkg::M_EXP;
                end else begin
                    do_fail = 1'b1;
                end
            end
            jts_pkg::M_EXP: begin
                if (!end_w && jts_pkg::is_digit(c)) begin
                    do_num   = 1'b1;
                    num_mode = jts_pkg::M_EXP;
                end else begin
                    do_close = 1'b1;
                end
            end
            default: begin
                // Halted after an error: drop bytes until the end of the text.
                if (end_w) begin
                    mode_next = jts_pkg::M_IDLE;
                    res_cnt   = 2'd1;
                end else begin
                    mode_next = jts_pkg::M_HALT;
                end
            end
        endcase

        if (do_fail) begin
            res0 = jts_pkg::mk_result(jts_pkg::K_ERROR, 8'h00, 1'b0, 1'b1);
            res1 = jts_pkg::mk_result(jts_pkg::K_EOF, 8'h00, 1'b0, 1'b1);
            if (end_w) begin
                res_cnt   = 2'd2;
                mode_next = jts_pkg::M_IDLE;
            end else begin
                res_cnt   = 2'd1;
                mode_next = jts_pkg::M_HALT;
            end
        end else if (do_num) begin
            res_cnt   = 2'd1;
            res0      = jts_pkg::mk_result(jts_pkg::K_NUMBER, c, 1'b1, 1'b0);
            mode_next = num_mode;
        end else if (do_close) begin
            // The closing byte is scanned again as the start of the next token.
            res_cnt   = idle_has ? 2'd2 : 2'd1;
            res0      = jts_pkg::mk_result(jts_pkg::K_NUMBER, 8'h00, 1'b0, 1'b1);
            res1      = idle_res;
            mode_next = idle_mode;
            if (idle_kw) begin
                kw_choice_next = idle_kc;
                kw_pos_next    = 3'd1;
            end
        end
    end

    always_comb begin
        in_valid_next     = in_valid_reg;
        out_valid_next    = out_valid_reg;
        out_next          = out_reg;
        second_valid_next = second_valid_reg;
        second_next       = second_reg;

        if (process) begin
            in_valid_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (second_valid_reg && out_free) begin
            out_valid_next    = 1'b1;
            out_next          = second_reg;
            second_valid_next = 1'b0;
        end else if (process && (res_cnt != 2'd0)) begin
            out_valid_next = 1'b1;
            out_next       = res0;
            if (res_cnt == 2'd2) begin
                second_valid_next = 1'b1;
                second_next       = res1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            second_valid_reg <= 1'b0;
            mode_reg         <= jts_pkg::M_IDLE;
            kw_choice_reg    <= 2'd0;
            kw_pos_reg       <= 3'd0;
            hex_seen_reg     <= 3'd0;
        end else begin
            in_valid_reg     <= in_valid_next;
            out_valid_reg    <= out_valid_next;
            second_valid_reg <= second_valid_next;
            if (process) begin
                mode_reg      <= mode_next;
                kw_choice_reg <= kw_choice_next;
                kw_pos_reg    <= kw_pos_next;
                hex_seen_reg  <= hex_seen_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        out_reg    <= out_next;
        second_reg <= second_next;
    end

endmodule

>>> sim/json_token_scanner_checker.sv
`timescale 1ns / 100ps
// Checker for the JSON token scanner: watches both channels, predicts result beats, compares.
module json_token_scanner_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic [4:0] m_tuser,
    input  logic       m_tlast,
    output int         fail_count,
    output int         pending,
    output int         results_checked,
    output int         tokens_closed
);

    jts_pkg::scan_mode_t mode;
    logic [1:0]          kw_sel;
    logic [2:0]          kw_pos;
    logic [2:0]          hex_count;
    jts_pkg::result_t    token_q[$];
    int                  bad_beats;
    int                  beats_seen;
    int                  tokens_seen;

    function automatic logic is_decimal_char(logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_hex_char(logic [7:0] c);
        return is_decimal_char(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
    endfunction

    // Decoded value of a single-letter escape; zero marks a letter that is not allowed.
    function automatic logic [7:0] escape_value(logic [7:0] c);
        logic [7:0] d;
        case (c)
            "\"":    d = "\"";
            "\\":    d = "\\";
            "/":     d = "/";
            "b":     d = 8'h08;
            "f":     d = 8'h0c;
            "n":     d = 8'h0a;
            "r":     d = 8'h0d;
            "t":     d = 8'h09;
            default: d = 8'h00;
        endcase
        return d;
    endfunction

    function automatic string keyword_text(logic [1:0] k);
        string w;
        case (k)
            jts_pkg::KW_TRUE:  w = "true";
            jts_pkg::KW_FALSE: w = "false";
            jts_pkg::KW_NULL:  w = "null";
            default:           w = "";
        endcase
        return w;
    endfunction

    function automatic jts_pkg::token_kind_t keyword_token(logic [1:0] k);
        jts_pkg::token_kind_t t;
        case (k)
            jts_pkg::KW_TRUE:  t = jts_pkg::K_TRUE;
            jts_pkg::KW_FALSE: t = jts_pkg::K_FALSE;
            jts_pkg::KW_NULL:  t = jts_pkg::K_NULL;
            default:           t = jts_pkg::K_ERROR;
        endcase
        return t;
    endfunction

    task automatic emit(input jts_pkg::token_kind_t k, input logic [7:0] b, input logic v,
                        input logic d);
        jts_pkg::result_t r;
        r.kind          = k;
        r.content       = b;
        r.content_valid = v;
        r.done          = d;
        token_q.push_back(r);
    endtask

    task automatic raise_error(input logic fin);
        emit(jts_pkg::K_ERROR, 8'h00, 1'b0, 1'b1);
        if (fin) begin
            emit(jts_pkg::K_EOF, 8'h00, 1'b0, 1'b1);
            mode = jts_pkg::M_IDLE;
        end else begin
            mode = jts_pkg::M_HALT;
        end
    endtask

    task automatic number_char(input logic [7:0] c, input jts_pkg::scan_mode_t next);
        mode = next;
        emit(jts_pkg::K_NUMBER, c, 1'b1, 1'b0);
    endtask

    task automatic start_token(input logic [7:0] c, input logic fin);
        mode = jts_pkg::M_IDLE;
        if (fin) begin
            emit(jts_pkg::K_EOF, 8'h00, 1'b0, 1'b1);
        end else begin
            case (c) inside
                8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d: ;
                "{": emit(jts_pkg::K_LBRACE, 8'h00, 1'b0, 1'b1);
                "}": emit(jts_pkg::K_RBRACE, 8'h00, 1'b0, 1'b1);
                "[": emit(jts_pkg::K_LBRACK, 8'h00, 1'b0, 1'b1);
                "]": emit(jts_pkg::K_RBRACK, 8'h00, 1'b0, 1'b1);
                ",": emit(jts_pkg::K_COMMA, 8'h00, 1'b0, 1'b1);
                ":": emit(jts_pkg::K_COLON, 8'h00, 1'b0, 1'b1);
                "\"": mode = jts_pkg::M_STR;
                "-": number_char(c, jts_pkg::M_MINUS);
                "0": number_char(c, jts_pkg::M_ZERO);
                "t", "f", "n": begin
                    kw_sel = (c == "t") ? jts_pkg::KW_TRUE :
                             (c == "f") ? jts_pkg::KW_FALSE : jts_pkg::KW_NULL;
                    kw_pos = 3'd1;
                    mode   = jts_pkg::M_KEY;
                end
                default: begin
                    if (is_decimal_char(c)) number_char(c, jts_pkg::M_INT);
                    else raise_error(1'b0);
                end
            endcase
        end
    endtask

    // The byte that ends a number is scanned again as the start of the next token.
    task automatic close_number(input logic [7:0] c, input logic fin);
        emit(jts_pkg::K_NUMBER, 8'h00, 1'b0, 1'b1);
        start_token(c, fin);
    endtask

    task automatic scan_byte(input logic [7:0] c, input logic eoi);
        logic       fin;
        logic       ex;
        logic [7:0] d;
        string      w;
        fin = eoi || (c == 8'h00);
        ex  = (c == "e") || (c == "E");
        case (mode) inside
            jts_pkg::M_IDLE: start_token(c, fin);
            jts_pkg::M_STR: begin
                if (fin) raise_error(1'b1);
                else if (c == "\"") begin
                    mode = jts_pkg::M_IDLE;
                    emit(jts_pkg::K_STRING, 8'h00, 1'b0, 1'b1);
                end else if (c == "\\") mode = jts_pkg::M_ESC;
                else emit(jts_pkg::K_STRING, c, 1'b1, 1'b0);
            end
            jts_pkg::M_ESC: begin
                d = escape_value(c);
                if (fin) raise_error(1'b1);
                else if (c == "u") begin
                    hex_count = 3'd0;
                    mode      = jts_pkg::M_HEX;
                end else if (d == 8'h00) raise_error(1'b0);
                else begin
                    mode = jts_pkg::M_STR;
                    emit(jts_pkg::K_STRING, d, 1'b1, 1'b0);
                end
            end
            jts_pkg::M_HEX: begin
                if (fin) raise_error(1'b1);
                else if (!is_hex_char(c)) raise_error(1'b0);
                else begin
                    hex_count = hex_count + 3'd1;
                    if (hex_count >= 3'd4) begin
                        hex_count = 3'd0;
                        mode      = jts_pkg::M_STR;
                    end
                end
            end
            jts_pkg::M_KEY: begin
                w = keyword_text(kw_sel);
                if (fin) raise_error(1'b1);
                else if ((kw_pos >= w.len()) || (c != w[kw_pos])) raise_error(1'b0);
                else begin
                    kw_pos = kw_pos + 3'd1;
                    if (kw_pos >= w.len()) begin
                        kw_pos = 3'd0;
                        mode   = jts_pkg::M_IDLE;
                        emit(keyword_token(kw_sel), 8'h00, 1'b0, 1'b1);
                    end
                end
            end
            jts_pkg::M_MINUS: begin
                if (fin) raise_error(1'b1);
                else if (c == "0") number_char(c, jts_pkg::M_ZERO);
                else if (is_decimal_char(c)) number_char(c, jts_pkg::M_INT);
                else raise_error(1'b0);
            end
            jts_pkg::M_ZERO, jts_pkg::M_INT: begin
                if (!fin && (mode == jts_pkg::M_INT) && is_decimal_char(c))
                    number_char(c, jts_pkg::M_INT);
                else if (!fin && (c == ".")) number_char(c, jts_pkg::M_DOT);
                else if (!fin && ex) number_char(c, jts_pkg::M_E);
                else close_number(c, fin);
            end
            jts_pkg::M_DOT: begin
                if (fin) raise_error(1'b1);
                else if (is_decimal_char(c)) number_char(c, jts_pkg::M_FRAC);
                else raise_error(1'b0);
            end
            jts_pkg::M_FRAC: begin
                if (!fin && is_decimal_char(c)) number_char(c, jts_pkg::M_FRAC);
                else if (!fin && ex) number_char(c, jts_pkg::M_E);
                else close_number(c, fin);
            end
            jts_pkg::M_E: begin
                if (fin) raise_error(1'b1);
                else if ((c == "+") || (c == "-")) number_char(c, jts_pkg::M_ESIGN);
                else if (is_decimal_char(c)) number_char(c, jts_pkg::M_EXP);
                else raise_error(1'b0);
            end
            jts_pkg::M_ESIGN: begin
                if (fin) raise_error(1'b1);
                else if (is_decimal_char(c)) number_char(c, jts_pkg::M_EXP);
                else raise_error(1'b0);
            end
            jts_pkg::M_EXP: begin
                if (!fin && is_decimal_char(c)) number_char(c, jts_pkg::M_EXP);
                else close_number(c, fin);
            end
            default: begin
                // After an error everything up to the end of the text is dropped.
                if (fin) begin
                    mode = jts_pkg::M_IDLE;
                    emit(jts_pkg::K_EOF, 8'h00, 1'b0, 1'b1);
                end else begin
                    mode = jts_pkg::M_HALT;
                end
            end
        endcase
    endtask

    task automatic check_beat();
        jts_pkg::result_t r;
        if (token_q.size() == 0) begin
            bad_beats++;
            if (bad_beats <= 10)
                $display("unexpected result beat: kind %0d byte %02h valid %0b done %0b",
                         m_tuser[3:0], m_tdata, m_tuser[4], m_tlast);
        end else begin
            r = token_q.pop_front();
            if ((r.kind !== m_tuser[3:0]) || (r.content !== m_tdata) ||
                (r.content_valid !== m_tuser[4]) || (r.done !== m_tlast)) begin
                bad_beats++;
                if (bad_beats <= 10)
                    $display({"mismatch at result beat %0d: expected kind %0d byte %02h ",
                              "valid %0b done %0b, got kind %0d byte %02h valid %0b done %0b"},
                             beats_seen, r.kind, r.content, r.content_valid, r.done,
                             m_tuser[3:0], m_tdata, m_tuser[4], m_tlast);
            end
        end
        beats_seen++;
        if (m_tlast === 1'b1) tokens_seen++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            mode      = jts_pkg::M_IDLE;
            kw_sel    = 2'd0;
            kw_pos    = 3'd0;
            hex_count = 3'd0;
            token_q.delete();
            bad_beats   = 0;
            beats_seen  = 0;
            tokens_seen = 0;
        end else begin
            if (s_tvalid && s_tready) scan_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) check_beat();
        end
        fail_count      <= bad_beats;
        pending         <= token_q.size();
        results_checked <= beats_seen;
        tokens_closed   <= tokens_seen;
    end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// Top of the JSON token scanner testbench: clock, reset, stimulus, back-pressure and verdict.
module testbench;

    localparam int TEXT_BYTES  = 500;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 100000;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [4:0] m_tuser;
    logic       m_tlast;

    int         fail_count;
    int         pending;
    int         results_checked;
    int         tokens_closed;

    logic [8:0] text_q[$];     // {end_of_input, text_byte}
    int         bytes_sent   = 0;
    int         texts_made   = 0;
    int         tx_idle_pct  = 14;
    int         rx_idle_pct  = 14;
    logic       hold_request = 1'b0;
    int         hold_left    = 0;
    int         cycles       = 0;
    logic       held         = 1'b0;
    logic       drained      = 1'b0;

    json_token_scanner_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    json_token_scanner_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .tokens_closed   (tokens_closed)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
            $display("** json_token_scanner_unit: FAILED **");
            $finish;
        end
    end

    // Output side: random back-pressure, plus one long hold-off on request.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_request) begin
            m_tready     <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            hold_request <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    function automatic logic [7:0] pick(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    task automatic push_byte(input logic [7:0] b);
        text_q.push_back({1'b0, b});
    endtask

    task automatic push_chars(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    task automatic push_digits(input int lo, input int hi);
        int n;
        n = $urandom_range(lo, hi);
        repeat (n) push_byte(8'(8'h30 + $urandom_range(0, 9)));
    endtask

    // A text ends either with a tlast beat carrying arbitrary data or with a plain zero byte.
    task automatic push_end();
        if ($urandom_range(0, 3) == 0) text_q.push_back({1'b0, 8'h00});
        else text_q.push_back({1'b1, 8'($urandom_range(0, 255))});
    endtask

    task automatic push_space();
        int r;
        r = $urandom_range(0, 5);
        push_byte((r == 5) ? 8'h20 : 8'(8'h09 + r));
    endtask

    task automatic push_string();
        int n;
        int r;
        push_byte("\"");
        n = $urandom_range(0, 6);
        repeat (n) begin
            r = $urandom_range(0, 9);
            case (r)
                0: begin
                    push_byte("\\");
                    push_byte(pick("\"\\/bfnrt"));
                end
                1: begin
                    push_chars("\\u");
                    repeat (4) push_byte(pick("0123456789abcdefABCDEF"));
                end
                2: push_byte(8'($urandom_range(1, 31)));
                3: push_byte(8'($urandom_range(128, 255)));
                default: push_byte(pick(" !#$%&'()*+,-./0123456789:;<=>?@AZaz[]^_`{|}~"));
            endcase
        end
        push_byte("\"");
    endtask

    task automatic push_number();
        if ($urandom_range(0, 1) == 0) push_byte("-");
        if ($urandom_range(0, 9) < 3) begin
            push_byte("0");
        end else begin
            push_byte(8'(8'h31 + $urandom_range(0, 8)));
            push_digits(0, 3);
        end
        if ($urandom_range(0, 9) < 4) begin
            push_byte(".");
            push_digits(1, 3);
        end
        if ($urandom_range(0, 9) < 4) begin
            push_byte(pick("eE"));
            case ($urandom_range(0, 2))
                0: push_byte("+");
                1: push_byte("-");
                default: ;
            endcase
            push_digits(1, 3);
        end
    endtask

    task automatic push_text(input logic broken);
        int first;
        int n;
        int r;
        int at;
        first = text_q.size();
        n = $urandom_range(1, 8);
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 30) push_byte(pick("{}[],:"));
            else if (r < 45) begin
                case ($urandom_range(0, 2))
                    0: push_chars("true");
                    1: push_chars("false");
                    default: push_chars("null");
                endcase
            end else if (r < 70) push_string();
            else push_number();
            repeat ($urandom_range(0, 2)) push_space();
        end
        // A broken text has one byte replaced, one byte inserted, or its tail cut off.
        if (broken) begin
            at = $urandom_range(first, text_q.size() - 1);
            case ($urandom_range(0, 2))
                0: text_q[at] = {1'b0, 8'($urandom_range(0, 255))};
                1: text_q.insert(at, {1'b0, 8'($urandom_range(0, 255))});
                default: while (text_q.size() > at) void'(text_q.pop_back());
            endcase
        end
        push_end();
        texts_made++;
    endtask

    task automatic send_beat(input logic [8:0] beat);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= beat[7:0];
        s_tlast  <= beat[8];
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_queued();
        while (text_q.size() > 0) send_beat(text_q.pop_front());
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: end of text while idle, a number closed by a comma, a string with escapes,
        // control and top-bit bytes cut short by the end, then a keyword mismatch ended by zero.
        text_q.push_back({1'b1, 8'h00});
        push_chars("[-0.5e+3,");
        push_chars("\"\\u00aF\\n");
        push_byte(8'h01);
        push_byte(8'hff);
        text_q.push_back({1'b1, 8'h5a});
        push_chars("tx");
        push_byte(8'h00);
        send_queued();

        while (bytes_sent < TEXT_BYTES) begin
            if ((bytes_sent >= 150) && (bytes_sent < 300)) begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
            end else if ((bytes_sent >= 300) && !held) begin
                // Sender keeps offering while the output is held, so the input backs up.
                held = 1'b1;
                tx_idle_pct = 0;
                rx_idle_pct <= 14;
                hold_request <= 1'b1;
            end else if ((bytes_sent >= 400) && !drained) begin
                drained = 1'b1;
                tx_idle_pct = 14;
                wait_drained();
            end else if (bytes_sent >= 300) begin
                tx_idle_pct = 14;
                rx_idle_pct <= 14;
            end
            push_text($urandom_range(0, 99) < 20);
            send_queued();
        end

        wait_drained();
        repeat (20) @(posedge aclk);

        $display("Sent %0d text bytes in %0d texts, well-formed and broken, with random gaps,",
                 bytes_sent, texts_made);
        $display("a long output hold and a full drain; %0d result beats and %0d tokens checked.",
                 results_checked, tokens_closed);
        if ((fail_count == 0) && (pending == 0)) begin
            $display("** json_token_scanner_unit: PASSED **");
        end else begin
            $display("** json_token_scanner_unit: FAILED **");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/jts_pkg.sv
rtl/core/json_token_scanner_unit.sv
sim/json_token_scanner_checker.sv
sim/testbench.sv
